// ----- sv/vc32_pkg.sv -----
package vc32_pkg;

	localparam logic OP_ENCODE = 1'b0;
	localparam logic OP_DECODE = 1'b1;

	localparam logic [2:0] MAX_BYTES = 3'd5;

	typedef enum logic [1:0] {
		KIND_BYTE  = 2'd0,
		KIND_VALUE = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	// one queued job: an encode value with its byte count, or a finished decode result or decode error
	typedef struct packed {
		kind_t       kind;
		logic [31:0] value;
		logic [2:0]  len;
	} entry_t;

endpackage

// ----- sv/vc32_front.sv -----
module vc32_front import vc32_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        operation,
	input  logic [31:0] value,
	input  logic [7:0]  in_byte,
	input  logic        buffer_end,
	input  logic        q_full,
	output logic        q_push,
	output entry_t      q_entry
);

	logic [31:0] acc_q;
	logic [2:0]  byte_count_q;

	logic        accept;
	logic [2:0]  cnt;
	logic [2:0]  cnt_next;
	logic [31:0] ins;
	logic [31:0] acc_new;
	logic [2:0]  enc_len;
	logic        dec_done;
	logic        dec_error;

	assign accept = push && !q_full;

	always_comb begin
		cnt = (byte_count_q > 3'd4) ? 3'd4 : byte_count_q;
		cnt_next = cnt + 3'd1;
		case (cnt)
			3'd0: ins = {25'd0, in_byte[6:0]};
			3'd1: ins = {18'd0, in_byte[6:0], 7'd0};
			3'd2: ins = {11'd0, in_byte[6:0], 14'd0};
			3'd3: ins = {4'd0, in_byte[6:0], 21'd0};
			3'd4: ins = {in_byte[3:0], 28'd0};
			default: ins = '0;
		endcase
		acc_new = acc_q | ins;
		dec_done = !in_byte[7];
		dec_error = in_byte[7] && (buffer_end || cnt_next >= MAX_BYTES);
	end

	always_comb begin
		if (value[31:28] != '0) begin
			enc_len = 3'd5;
		end else if (value[27:21] != '0) begin
			enc_len = 3'd4;
		end else if (value[20:14] != '0) begin
			enc_len = 3'd3;
		end else if (value[13:7] != '0) begin
			enc_len = 3'd2;
		end else begin
			enc_len = 3'd1;
		end
	end

	always_comb begin
		q_push = 1'b0;
		q_entry.kind = KIND_BYTE;
		q_entry.value = value;
		q_entry.len = enc_len;
		if (accept) begin
			if (operation == OP_ENCODE) begin
				q_push = 1'b1;
			end else if (dec_done) begin
				q_push = 1'b1;
				q_entry.kind = KIND_VALUE;
				q_entry.value = acc_new;
				q_entry.len = cnt_next;
			end else if (dec_error) begin
				q_push = 1'b1;
				q_entry.kind = KIND_ERROR;
				q_entry.value = '0;
				q_entry.len = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			byte_count_q <= '0;
		end else if (accept && operation == OP_DECODE) begin
			if (dec_done || dec_error) begin
				acc_q <= '0;
				byte_count_q <= '0;
			end else begin
				acc_q <= acc_new;
				byte_count_q <= cnt_next;
			end
		end
	end

endmodule

// ----- sv/vc32_queue.sv -----
module vc32_queue import vc32_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   wr,
	input  entry_t wr_entry,
	output logic   full,
	input  logic   rd,
	output entry_t rd_entry,
	output logic   empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	entry_t             mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	logic do_wr;
	logic do_rd;

	assign full = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_wr, do_rd})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- sv/vc32_back.sv -----
module vc32_back import vc32_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  entry_t      q_entry,
	input  logic        q_empty,
	output logic        q_pop,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  result_kind,
	output logic [7:0]  out_byte,
	output logic        out_last,
	output logic [31:0] decoded_value,
	output logic [2:0]  length
);

	logic [2:0] idx_q;
	logic       out_valid_q;
	kind_t      kind_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic [31:0] val_q;
	logic [2:0] len_q;

	logic       is_enc;
	logic       gen_last;
	logic       load;
	logic [6:0] chunk;
	logic [7:0] gen_byte;

	assign is_enc = (q_entry.kind == KIND_BYTE);
	assign gen_last = !is_enc || (idx_q + 3'd1 == q_entry.len);
	assign load = !q_empty && (!out_valid_q || pop);
	assign q_pop = load && gen_last;

	always_comb begin
		case (idx_q)
			3'd0: chunk = q_entry.value[6:0];
			3'd1: chunk = q_entry.value[13:7];
			3'd2: chunk = q_entry.value[20:14];
			3'd3: chunk = q_entry.value[27:21];
			3'd4: chunk = {3'd0, q_entry.value[31:28]};
			default: chunk = '0;
		endcase
		gen_byte = is_enc ? {!gen_last, chunk} : 8'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= gen_last ? 3'd0 : idx_q + 3'd1;
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= q_entry.kind;
			byte_q <= gen_byte;
			last_q <= gen_last;
			val_q <= is_enc ? 32'd0 : q_entry.value;
			len_q <= q_entry.len;
		end
	end

	assign empty = !out_valid_q;
	assign result_kind = kind_q;
	assign out_byte = byte_q;
	assign out_last = last_q;
	assign decoded_value = val_q;
	assign length = len_q;

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		!q_empty && is_enc |-> idx_q < q_entry.len)
		else $error("byte index past encoded length");

	a_idx_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_empty |-> idx_q == 3'd0)
		else $error("byte index not cleared with queue empty");

	a_enc_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q == KIND_BYTE |-> len_q >= 3'd1 && len_q <= MAX_BYTES)
		else $error("encoded length out of range");

	a_enc_cont: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q == KIND_BYTE |-> byte_q[7] == !last_q)
		else $error("continuation bit does not match last flag");

endmodule

// ----- sv/varint_codec_32_unit.sv -----
// Unsigned 32-bit LEB128 varint encoder and streaming decoder.
// Requests enter through push/full: operation 0 encodes value, operation 1 feeds
// one byte (in_byte, buffer_end) into the decoder. A request is taken on a clock
// edge with push high and full low.
// Results leave through empty/pop: the oldest result sits on result_kind,
// out_byte, out_last, decoded_value and length while empty is low, and is taken
// on an edge with pop high.
// The front classifies each request and runs the decode accumulator, one byte per
// cycle while full is low; it queues encode jobs, decode results and decode errors
// (QDEPTH entries). The back turns an encode job into one byte per cycle while
// pop keeps up, 1 to 5 bytes (its encoded length); decode results and errors give
// one result each. Continued decode bytes produce nothing and queue nothing.
// A request's first result is registered in the queue, then in the output register.
// If pop stays low the output register holds its result, the queue fills and full
// rises; requests are taken again as soon as a queue slot frees.
// Reset clears the decode accumulator and byte count and empties queue and output.
module varint_codec_32_unit import vc32_pkg::*; #(
	parameter int QDEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        operation,
	input  logic [31:0] value,
	input  logic [7:0]  in_byte,
	input  logic        buffer_end,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  result_kind,
	output logic [7:0]  out_byte,
	output logic        out_last,
	output logic [31:0] decoded_value,
	output logic [2:0]  length
);

	logic   q_push;
	logic   q_full;
	logic   q_pop;
	logic   q_empty;
	entry_t wr_entry;
	entry_t rd_entry;

	assign full = q_full;

	vc32_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.operation  (operation),
		.value      (value),
		.in_byte    (in_byte),
		.buffer_end (buffer_end),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_entry    (wr_entry)
	);

	vc32_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (q_push),
		.wr_entry (wr_entry),
		.full     (q_full),
		.rd       (q_pop),
		.rd_entry (rd_entry),
		.empty    (q_empty)
	);

	vc32_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_entry       (rd_entry),
		.q_empty       (q_empty),
		.q_pop         (q_pop),
		.empty         (empty),
		.pop           (pop),
		.result_kind   (result_kind),
		.out_byte      (out_byte),
		.out_last      (out_last),
		.decoded_value (decoded_value),
		.length        (length)
	);

endmodule
